FILE: hdl/mffs_pkg.sv
// ----------------------------------------------------------------------------
// mffs_pkg
// Shared types and constants of the msb-first field serialiser.
// ----------------------------------------------------------------------------
package mffs_pkg;

  // field widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = $clog2(VALUE_W);
  localparam int unsigned S_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  // operation codes carried on s_tuser
  typedef enum logic {
    OP_BITS  = 1'b0,
    OP_BYTES = 1'b1
  } op_t;

endpackage

FILE: hdl/msb_first_field_serializer.sv
// ----------------------------------------------------------------------------
// msb_first_field_serializer
// Packs fields msb first into bytes, or emits whole bytes big-endian.
//
//   channel   dir   contents
//   s_*       in    tdata {field_count, field_value}, tuser opcode
//   m_*       out   tdata out_byte, tuser error, tlast last word of the item
//
// After acceptance a bit-mode item moves one bit per cycle through the bit
// accumulator, save while a finished byte waits on a stalled output; a
// byte-mode item sends field_count bytes, most significant first, as the
// output drains. No item is taken while one runs or the output stalls; zero
// count or an error ends an item on acceptance. Words use one output register.
// Reset (rst, synchronous) clears the accumulator and empties the output.
// ----------------------------------------------------------------------------
module msb_first_field_serializer #(
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned VALUE_BYTES = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // input words
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mffs_pkg::S_TDATA_W-1:0]   s_tdata,  // field_value, field_count
  input  logic [0:0]                       s_tuser,  // opcode
  // output words
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mffs_pkg::BYTE_W-1:0]      m_tdata,  // out_byte
  output logic                             m_tlast,
  output logic [0:0]                       m_tuser   // error
);

  localparam int unsigned CMP_W = mffs_pkg::COUNT_W + 1;
  localparam int unsigned VW    = mffs_pkg::VALUE_W;
  localparam int unsigned CW    = mffs_pkg::COUNT_W;
  localparam int unsigned BW    = mffs_pkg::BYTE_W;
  localparam int unsigned PW    = mffs_pkg::POS_W;
  localparam int unsigned LANES = VW / BW;
  localparam int unsigned LW    = $clog2(LANES);

  typedef enum logic {IDLE, RUN} state_t;

  state_t              state;
  mffs_pkg::op_t       mode;
  logic [VW-1:0]       val;
  logic [CW-1:0]       cnt;
  logic [BW-2:0]       acc;
  logic [2:0]          held;

  // input field views
  logic [VW-1:0]       in_value;
  logic [CW-1:0]       in_count;
  mffs_pkg::op_t       in_op;
  logic                in_err;

  assign in_value = s_tdata[VW-1:0];
  assign in_count = s_tdata[VW+CW-1:VW];
  assign in_op    = mffs_pkg::op_t'(s_tuser[0]);

  // count range check
  always_comb begin
    if (in_op == mffs_pkg::OP_BITS) begin
      in_err = {1'b0, in_count} > CMP_W'(VALUE_BITS);
    end else begin
      in_err = {1'b0, in_count} > CMP_W'(VALUE_BYTES);
    end
  end

  // current digit, bits above the value read as zero
  logic [CW-1:0] pos;
  logic          cur_bit;
  logic [BW-1:0] cur_byte;
  logic [BW-1:0] bit_word;
  logic          slot_free;
  logic          emit;
  logic          step;
  logic          load;

  assign pos      = cnt - CW'(1);
  assign cur_bit  = (pos >= CW'(VW)) ? 1'b0 : val[pos[PW-1:0]];
  assign cur_byte = (pos >= CW'(LANES)) ? '0 : val[{pos[LW-1:0], 3'b000} +: BW];
  assign bit_word = {acc, cur_bit};

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == IDLE) && slot_free;
  assign emit      = (mode == mffs_pkg::OP_BYTES) || (held == 3'd7);
  assign step      = (state == RUN) && (!emit || slot_free);

  // output register takes an error word or a finished byte
  assign load = ((state == IDLE) && s_tvalid && s_tready && (in_count != '0) && in_err)
             || (step && emit);

  // control, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      acc      <= '0;
      held     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid && s_tready && in_count != '0) begin
            if (in_err) begin
              m_tdata    <= '0;
              m_tlast    <= 1'b1;
              m_tuser[0] <= 1'b1;
            end else begin
              mode  <= in_op;
              val   <= in_value;
              cnt   <= in_count;
              state <= RUN;
            end
          end
        end
        RUN: begin
          if (step) begin
            cnt <= pos;
            if (cnt == CW'(1)) begin
              state <= IDLE;
            end
            if (mode == mffs_pkg::OP_BYTES) begin
              m_tdata    <= cur_byte;
              m_tlast    <= (cnt == CW'(1));
              m_tuser[0] <= 1'b0;
            end else if (held == 3'd7) begin
              // byte complete; last of the item when later bits cannot fill another one
              m_tdata    <= bit_word;
              m_tlast    <= (cnt <= CW'(BW));
              m_tuser[0] <= 1'b0;
              acc        <= '0;
              held       <= '0;
            end else begin
              acc  <= bit_word[BW-2:0];
              held <= held + 3'd1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/mffs_checker.sv
// ----------------------------------------------------------------------------
// mffs_checker
// Port-level checks of the msb-first field serialiser, bound to the top.
// ----------------------------------------------------------------------------
module mffs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mffs_pkg::BYTE_W-1:0]   m_tdata,
  input logic                          m_tlast,
  input logic [0:0]                    m_tuser
);

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output word present after reset");

  // an error word is a lone zero word closing its item
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && m_tlast))
    else $error("error word not zero or not last");

  // a new word is only taken when the output slot can drain
  a_accept_slot: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input taken while output stalled");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output word changed");

endmodule

bind msb_first_field_serializer mffs_checker u_mffs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the msb-first field serialiser: directed words for
// bit packing, byte emission and count limits, then a random mix of words
// with bursty input and a stalling output; every output word is compared
// with a local packing model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned VALUE_W     = mffs_pkg::VALUE_W;
  localparam int unsigned COUNT_W     = mffs_pkg::COUNT_W;
  localparam int unsigned BYTE_W      = mffs_pkg::BYTE_W;
  localparam int unsigned S_TDATA_W   = mffs_pkg::S_TDATA_W;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned VALUE_BYTES = 4;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_WAIT  = 80;

  // one output word as predicted
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } out_word_t;

  // receive-side stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // field_value, field_count
  logic [0:0]           s_tuser = '0;  // opcode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;       // out_byte
  logic                 m_tlast;
  logic [0:0]           m_tuser;       // error

  out_word_t   expected_bytes[$];
  logic [6:0]  pend_bits  = '0;
  logic [2:0]  pend_count = '0;
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  stall_tick = '0;
  rx_mode_t    stall_mode = RX_OPEN;

  msb_first_field_serializer #(
    .VALUE_BITS  (VALUE_BITS),
    .VALUE_BYTES (VALUE_BYTES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // packing model: queue the output words one input word causes
  function automatic void pack_fields(mffs_pkg::op_t op, logic [VALUE_W-1:0] value,
                                      logic [COUNT_W-1:0] count);
    logic [7:0]  acc;
    int unsigned held;
    int unsigned queued;
    out_word_t   w;
    queued = expected_bytes.size();
    if (count == 0) return;
    // oversized count: single error word, state untouched
    if ((op == mffs_pkg::OP_BITS && count > VALUE_BITS) ||
        (op == mffs_pkg::OP_BYTES && count > VALUE_BYTES)) begin
      expected_bytes.push_back('{data: '0, last: 1'b1, err: 1'b1});
      return;
    end
    if (op == mffs_pkg::OP_BITS) begin
      acc  = {1'b0, pend_bits};
      held = pend_count;
      for (int i = int'(count) - 1; i >= 0; i--) begin
        acc = {acc[6:0], value[i]};
        held++;
        if (held == 8) begin
          expected_bytes.push_back('{data: acc, last: 1'b0, err: 1'b0});
          acc  = '0;
          held = 0;
        end
      end
      pend_bits  = acc[6:0];
      pend_count = held[2:0];
    end else begin
      // big-endian bytes, pending bits left alone
      for (int i = int'(count) - 1; i >= 0; i--)
        expected_bytes.push_back('{data: value[8*i +: 8], last: 1'b0, err: 1'b0});
    end
    if (expected_bytes.size() > queued) begin
      w = expected_bytes.pop_back();
      w.last = 1'b1;
      expected_bytes.push_back(w);
    end
  endfunction

  // send one word, with bursts and random gaps between them
  task automatic send_word(mffs_pkg::op_t op, logic [VALUE_W-1:0] value,
                           logic [COUNT_W-1:0] count);
    logic [S_TDATA_W-1:0] word;
    int unsigned          gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[VALUE_W-1:0]               = value;
    word[VALUE_W +: COUNT_W]        = count;
    s_tdata  <= word;
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pack_fields(op, value, count);
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // bit accumulation across words, partial bytes held back
  task automatic test_bit_packing();
    send_word(mffs_pkg::OP_BITS, 32'h0000_0001, 6'd1);
    send_word(mffs_pkg::OP_BITS, 32'h0000_0055, 6'd7);
    send_word(mffs_pkg::OP_BITS, 32'hFFFF_FFFF, 6'd32);
    send_word(mffs_pkg::OP_BITS, 32'h0000_0000, 6'd32);
    send_word(mffs_pkg::OP_BITS, 32'h0000_000A, 6'd4);
    send_word(mffs_pkg::OP_BITS, 32'h8000_0001, 6'd32);
    send_word(mffs_pkg::OP_BITS, 32'h0000_0003, 6'd4);
    send_word(mffs_pkg::OP_BITS, 32'h7FFF_FFFF, 6'd31);
    send_word(mffs_pkg::OP_BITS, 32'hFFFF_FFFE, 6'd1);
  endtask

  // whole bytes, including with bits pending in the accumulator
  task automatic test_byte_emission();
    send_word(mffs_pkg::OP_BITS,  32'h0000_0005, 6'd3);
    send_word(mffs_pkg::OP_BYTES, 32'h89AB_CDEF, 6'd4);
    send_word(mffs_pkg::OP_BYTES, 32'h0000_00FF, 6'd1);
    send_word(mffs_pkg::OP_BYTES, 32'h1234_5678, 6'd2);
    send_word(mffs_pkg::OP_BYTES, 32'hFFFF_FF00, 6'd3);
    send_word(mffs_pkg::OP_BITS,  32'h0000_0013, 6'd5);
  endtask

  // zero counts and counts past the value width
  task automatic test_count_limits();
    send_word(mffs_pkg::OP_BITS,  32'hDEAD_BEEF, 6'd0);
    send_word(mffs_pkg::OP_BYTES, 32'hDEAD_BEEF, 6'd0);
    send_word(mffs_pkg::OP_BITS,  32'hFFFF_FFFF, 6'd33);
    send_word(mffs_pkg::OP_BITS,  32'hFFFF_FFFF, 6'd63);
    send_word(mffs_pkg::OP_BYTES, 32'hFFFF_FFFF, 6'd5);
    send_word(mffs_pkg::OP_BYTES, 32'hA5A5_A5A5, 6'd63);
    send_word(mffs_pkg::OP_BITS,  32'h0000_0001, 6'd2);
  endtask

  // random mix, mostly well-formed packing with some odd counts
  task automatic test_random_mix(int unsigned n_words);
    mffs_pkg::op_t      op;
    logic [COUNT_W-1:0] count;
    int unsigned        kind;
    for (int unsigned k = 0; k < n_words; k++) begin
      kind = $urandom_range(0, 99);
      op   = ($urandom_range(0, 1) == 0) ? mffs_pkg::OP_BITS : mffs_pkg::OP_BYTES;
      if (kind < 60) begin
        op    = mffs_pkg::OP_BITS;
        count = ($urandom_range(0, 2) == 0) ? COUNT_W'($urandom_range(1, 7))
                                            : COUNT_W'($urandom_range(1, 32));
      end else if (kind < 82) begin
        op    = mffs_pkg::OP_BYTES;
        count = COUNT_W'($urandom_range(1, VALUE_BYTES));
      end else if (kind < 90) begin
        count = '0;
      end else if (op == mffs_pkg::OP_BITS) begin
        count = COUNT_W'($urandom_range(VALUE_BITS + 1, 63));
      end else begin
        count = COUNT_W'($urandom_range(VALUE_BYTES + 1, 63));
      end
      send_word(op, $urandom, count);
    end
  endtask

  // sender holds off until every word has come out, then resumes
  task automatic test_pause_until_drained();
    test_random_mix(10);
    idle_sender();
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    test_random_mix(10);
  endtask

  // output stalls on a changing pattern
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= rx_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (stall_tick[2:0] != 3'd5) && (stall_tick[2:0] != 3'd6);
    endcase
  end

  // compare each output word with the oldest prediction
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word data=%02h last=%0b err=%0b",
                 $realtime, m_tdata, m_tlast, m_tuser);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.data) begin
          $display("%0t: data expected %02h actual %02h", $realtime, want.data, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, want.last, m_tlast);
          fail_count++;
        end
        if (m_tuser[0] !== want.err) begin
          $display("%0t: error expected %0b actual %0b", $realtime, want.err, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_bit_packing();
    test_byte_emission();
    test_count_limits();
    test_random_mix(110);
    test_pause_until_drained();
    test_random_mix(20);
    idle_sender();
    do @(posedge clk); while (expected_bytes.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mffs_pkg.sv
hdl/msb_first_field_serializer.sv
hdl/mffs_checker.sv
sim/testbench.sv
